// ----- hw/rtl/msts_pkg.sv -----
package msts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 9;
  localparam int DATA_W      = 32;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [DEPTH_W-1:0]       depth;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic [PTR_W-1:0]         cnt;
  } min_entry_t;

  typedef enum logic {
    S_IDLE,
    S_POP_RD
  } state_t;

endpackage

// ----- hw/rtl/min_tracking_stack_unit.sv -----
// Stack of signed 32-bit values that also reports the minimum of what it holds.
// Requests arrive on the in_ channel (op and value) and each one produces
// exactly one response on the out_ channel carrying the top of stack, the
// current minimum, the depth and a status code, all as they stand after the
// request. An empty stack reports the most negative value for top and minimum.
// For push, peek and a pop of an empty stack the response is registered at
// the accepting edge and shows on out_valid in the next cycle.
// A pop of a non-empty stack passes through the S_POP_RD state, because the
// new top and, when the minimum retires, the previous minimum entry come back
// from the synchronous value and minimum memories in the cycle after the read
// is issued; in_stall stays high in S_POP_RD. Otherwise one request per cycle is
// taken. A new request is taken only when the response register is empty or
// being drained in the same cycle, so a stalled receiver holds off the in_
// channel through in_stall, and the held response does not change.
// Reset clears both stack pointers and the control state; the memories are not
// cleared, as only entries below a pointer are ever used.
module min_tracking_stack_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  msts_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output msts_pkg::rsp_t out_rsp
);

  msts_pkg::state_t state_r, state_nxt;

  logic [msts_pkg::PTR_W-1:0]        vptr_r, vptr_nxt;
  logic [msts_pkg::PTR_W-1:0]        mptr_r, mptr_nxt;
  logic signed [msts_pkg::DATA_W-1:0] top_r, top_nxt;
  logic signed [msts_pkg::DATA_W-1:0] min_r, min_nxt;
  logic [msts_pkg::PTR_W-1:0]        cnt_r, cnt_nxt;
  logic                              retire_r, retire_nxt;
  logic                              out_valid_r, out_valid_nxt;
  msts_pkg::rsp_t                    rsp_r, rsp_nxt;

  logic accept;
  logic is_pop;

  logic                              vram_we;
  logic [msts_pkg::ADDR_W-1:0]       vram_waddr;
  logic [msts_pkg::ADDR_W-1:0]       vram_raddr;
  logic [msts_pkg::DATA_W-1:0]       vram_rdata;

  logic                              mram_we;
  logic [msts_pkg::ADDR_W-1:0]       mram_waddr;
  msts_pkg::min_entry_t              mram_wdata;
  logic [msts_pkg::ADDR_W-1:0]       mram_raddr;
  msts_pkg::min_entry_t              mram_rdata;

  assign in_stall  = (state_r != msts_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign is_pop    = (in_req.op == msts_pkg::OP_POP);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msts_pkg::S_IDLE: begin
        if (accept && is_pop && (vptr_r != '0)) begin
          state_nxt = msts_pkg::S_POP_RD;
        end
      end
      msts_pkg::S_POP_RD: begin
        state_nxt = msts_pkg::S_IDLE;
      end
      default: state_nxt = msts_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    vptr_nxt      = vptr_r;
    mptr_nxt      = mptr_r;
    top_nxt       = top_r;
    min_nxt       = min_r;
    cnt_nxt       = cnt_r;
    retire_nxt    = retire_r;
    out_valid_nxt = out_valid_r && out_stall;
    rsp_nxt       = rsp_r;

    vram_we    = 1'b0;
    vram_waddr = msts_pkg::ADDR_W'(vptr_r);
    vram_raddr = msts_pkg::ADDR_W'(vptr_r - msts_pkg::PTR_W'(2));
    mram_we    = 1'b0;
    mram_waddr = msts_pkg::ADDR_W'(mptr_r - msts_pkg::PTR_W'(1));
    mram_wdata = '{val: min_r, cnt: cnt_r};
    mram_raddr = msts_pkg::ADDR_W'(mptr_r - msts_pkg::PTR_W'(2));

    unique case (state_r)
      msts_pkg::S_IDLE: begin
        if (accept) begin
          rsp_nxt.status = msts_pkg::ST_DONE;
          unique case (in_req.op)
            msts_pkg::OP_PUSH: begin
              if (vptr_r >= msts_pkg::PTR_W'(msts_pkg::STACK_DEPTH)) begin
                rsp_nxt.status = msts_pkg::ST_PUSH_FULL;
              end else begin
                vram_we  = 1'b1;
                vptr_nxt = vptr_r + msts_pkg::PTR_W'(1);
                top_nxt  = in_req.value;
                if ((mptr_r == '0) || ($signed(in_req.value) < $signed(min_r))) begin
                  // A new smallest value opens a fresh minimum entry.
                  mram_we    = 1'b1;
                  mram_waddr = msts_pkg::ADDR_W'(mptr_r);
                  mram_wdata = '{val: in_req.value, cnt: msts_pkg::PTR_W'(1)};
                  mptr_nxt   = mptr_r + msts_pkg::PTR_W'(1);
                  min_nxt    = in_req.value;
                  cnt_nxt    = msts_pkg::PTR_W'(1);
                end else if (in_req.value == min_r) begin
                  cnt_nxt    = cnt_r + msts_pkg::PTR_W'(1);
                  mram_we    = 1'b1;
                  mram_wdata = '{val: min_r, cnt: cnt_nxt};
                end
              end
            end
            msts_pkg::OP_POP: begin
              if (vptr_r == '0) begin
                rsp_nxt.status = msts_pkg::ST_POP_EMPTY;
              end else begin
                // The new top and the older minimum entry are read here and
                // picked up in the following cycle.
                vptr_nxt   = vptr_r - msts_pkg::PTR_W'(1);
                retire_nxt = 1'b0;
                if ((mptr_r != '0) && (top_r == min_r)) begin
                  if (cnt_r <= msts_pkg::PTR_W'(1)) begin
                    mptr_nxt   = mptr_r - msts_pkg::PTR_W'(1);
                    retire_nxt = 1'b1;
                  end else begin
                    cnt_nxt    = cnt_r - msts_pkg::PTR_W'(1);
                    mram_we    = 1'b1;
                    mram_wdata = '{val: min_r, cnt: cnt_nxt};
                  end
                end
              end
            end
            default: begin
            end
          endcase

          if (!(is_pop && (vptr_r != '0))) begin
            out_valid_nxt     = 1'b1;
            rsp_nxt.top_value = (vptr_nxt != '0) ? top_nxt : msts_pkg::MOST_NEG;
            rsp_nxt.min_value = ((vptr_nxt != '0) && (mptr_nxt != '0)) ? min_nxt
                                                                      : msts_pkg::MOST_NEG;
            rsp_nxt.depth     = msts_pkg::DEPTH_W'({{msts_pkg::DEPTH_W{1'b0}}, vptr_nxt});
          end else begin
            out_valid_nxt = 1'b0;
          end
        end
      end
      msts_pkg::S_POP_RD: begin
        top_nxt = vram_rdata;
        if (retire_r) begin
          min_nxt = mram_rdata.val;
          cnt_nxt = mram_rdata.cnt;
        end
        out_valid_nxt     = 1'b1;
        rsp_nxt.top_value = (vptr_r != '0) ? top_nxt : msts_pkg::MOST_NEG;
        rsp_nxt.min_value = ((vptr_r != '0) && (mptr_r != '0)) ? min_nxt
                                                              : msts_pkg::MOST_NEG;
        rsp_nxt.depth     = msts_pkg::DEPTH_W'({{msts_pkg::DEPTH_W{1'b0}}, vptr_r});
        rsp_nxt.status    = msts_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msts_pkg::S_IDLE;
      vptr_r      <= '0;
      mptr_r      <= '0;
      retire_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vptr_r      <= vptr_nxt;
      mptr_r      <= mptr_nxt;
      retire_r    <= retire_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    min_r <= min_nxt;
    cnt_r <= cnt_nxt;
    rsp_r <= rsp_nxt;
  end

  msts_ram #(
    .WIDTH(msts_pkg::DATA_W),
    .DEPTH(msts_pkg::STACK_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (in_req.value),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  msts_ram #(
    .WIDTH($bits(msts_pkg::min_entry_t)),
    .DEPTH(msts_pkg::STACK_DEPTH)
  ) u_min_ram (
    .clk   (clk),
    .we    (mram_we),
    .waddr (mram_waddr),
    .wdata (mram_wdata),
    .raddr (mram_raddr),
    .rdata (mram_rdata)
  );

endmodule

// ----- hw/rtl/msts_ram.sv -----
module msts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
